FILE: design/pls_pkg.sv
// Shared types and constants for the positional list store.
// Holds the request and status codes, the cell command and the result record.
// No dependencies.
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 4;
  localparam int POS_W    = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [POS_W-1:0]         pos_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 4'd0,
    REQ_INS_REAR  = 4'd1,
    REQ_DEL_FRONT = 4'd2,
    REQ_DEL_REAR  = 4'd3,
    REQ_INS_POS   = 4'd4,
    REQ_DEL_POS   = 4'd5,
    REQ_SEARCH    = 4'd6,
    REQ_REVERSE   = 4'd7,
    REQ_DISPLAY   = 4'd8,
    REQ_COUNT     = 4'd9
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_SWAP,
    CELL_ROT
  } cell_op_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t op;
    cnt_t     idx;
    cnt_t     n;
    logic     par;
    data_t    value;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWAP,
    ST_FIN,
    ST_DISP
  } state_t;

  typedef struct packed {
    status_t status;
    data_t   value;
    logic    found;
    pos_t    fpos;
    pos_t    count;
    logic    last;
  } result_t;

endpackage

FILE: design/pls_cell.sv
// One storage cell of the list row: holds one entry and trades it with its neighbors.
// Depends on pls_pkg for the cell command and data types.
module pls_cell (
  input  logic                      clk,
  input  pls_pkg::cell_cmd_t        cmd,
  input  logic [pls_pkg::IDX_W-1:0] cell_id,
  input  pls_pkg::data_t            left_data,
  input  pls_pkg::data_t            right_data,
  output pls_pkg::data_t            data,
  output logic                      hit
);
  import pls_pkg::*;

  data_t data_r;
  data_t data_nxt;
  cnt_t  me;
  cnt_t  me_p1;

  assign me    = cnt_t'(cell_id);
  assign me_p1 = me + cnt_t'(1);

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INS: begin
        // Cells behind the gap move one place toward the rear.
        if (me > cmd.idx) begin
          data_nxt = left_data;
        end else if (me == cmd.idx) begin
          data_nxt = cmd.value;
        end
      end
      CELL_DEL: begin
        if (me >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      CELL_SWAP: begin
        // One round of neighbor swaps; the round parity picks the pairs.
        if ((me[0] == cmd.par) && (me_p1 < cmd.n)) begin
          data_nxt = right_data;
        end else if ((me[0] != cmd.par) && (me != '0) && (me < cmd.n)) begin
          data_nxt = left_data;
        end
      end
      CELL_ROT: begin
        if (me_p1 == cmd.n) begin
          data_nxt = cmd.value;
        end else if (me_p1 < cmd.n) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = (data_r == cmd.value);

endmodule

FILE: design/positional_list_store.sv
// Top level of the positional list store: request decode, sequencer, cell row
// and result register. Depends on pls_pkg and pls_cell.
//
//   Channel  Direction  Handshake            Payload
//   in_      request    in_valid / in_stall  req_type, item_value, position
//   out_     result     out_valid/out_stall  status, value, found, found_position,
//                                            entry_count, last
//
// A request is latched in the idle state and carried out in the EXEC state, where a
// stalled output holds it; inserts, deletes, searches and count queries finish there.
// A reverse takes count rounds of neighbor swaps in the cell row, then waits in FIN
// for a free output; a display rotates the row once per emitted entry and waits on
// a stalled output before each entry.
// Reset (rst_n low, synchronous) empties the list; entry contents are not cleared.
// The block holds in_stall high from acceptance until the last result is written
// into the output register, and a result may wait there while a new request is taken.
module positional_list_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [pls_pkg::REQ_W-1:0] in_req_type,
  input  pls_pkg::data_t            in_item_value,
  input  pls_pkg::pos_t             in_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pls_pkg::status_t          out_status,
  output pls_pkg::data_t            out_value,
  output logic                      out_found,
  output pls_pkg::pos_t             out_found_position,
  output pls_pkg::pos_t             out_entry_count,
  output logic                      out_last
);
  import pls_pkg::*;

  // Sequencer and request registers.
  state_t            state_r, state_nxt;
  logic [REQ_W-1:0]  req_r;
  data_t             val_r;
  pos_t              pos_r;
  cnt_t              count_r, count_nxt;
  cnt_t              round_r, round_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r, res_nxt;
  logic              emit;

  // Cell row.
  cell_cmd_t         cmd;
  data_t             cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;

  // Decode.
  logic              empty, full, single, out_free, last_step;
  logic              ins_pos_ok, del_pos_ok;
  cnt_t              pos_idx, del_idx;
  data_t             del_val;
  logic              hit_any;
  logic [IDX_W-1:0]  hit_idx;
  pos_t              count_ext;

  // The row of cells. End cells see zero past the ends of the row.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t left_d;
    data_t right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[g+1];
    end
    pls_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_id    (IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

  // Checks on the latched request against the current list.
  always_comb begin
    count_ext  = pos_t'(count_r);
    empty      = (count_r == '0);
    full       = (count_r == cnt_t'(CAPACITY));
    single     = (count_r == cnt_t'(1));
    out_free   = !out_valid_r || !out_stall;
    last_step  = (round_r == (count_r - cnt_t'(1)));
    ins_pos_ok = (pos_r != '0) && (pos_r <= (count_ext + pos_t'(1)));
    del_pos_ok = (pos_r != '0) && (pos_r <= count_ext);
    pos_idx    = cnt_t'(pos_r - pos_t'(1));

    case (req_t'(req_r))
      REQ_DEL_FRONT: del_idx = '0;
      REQ_DEL_REAR:  del_idx = count_r - cnt_t'(1);
      default:       del_idx = pos_idx;
    endcase

    del_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cnt_t'(i) == del_idx) begin
        del_val = cell_data[i];
      end
    end

    // First match wins, so scan from the rear and let lower cells override.
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_hit[i] && (cnt_t'(i) < count_r)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_t'(req_r))
          REQ_REVERSE: begin
            if (empty || single) begin
              if (out_free) begin
                state_nxt = ST_IDLE;
              end
            end else begin
              state_nxt = ST_SWAP;
            end
          end
          REQ_DISPLAY: begin
            if (empty) begin
              if (out_free) begin
                state_nxt = ST_IDLE;
              end
            end else begin
              state_nxt = ST_DISP;
            end
          end
          default: begin
            if (out_free) begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_SWAP: begin
        if (last_step) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DISP: begin
        if (out_free && last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Cell commands, count update and result formation.
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.idx   = '0;
    cmd.n     = count_r;
    cmd.par   = round_r[0];
    cmd.value = val_r;
    emit      = 1'b0;
    count_nxt = count_r;
    round_nxt = round_r;
    res_nxt   = '{status: STAT_OK, value: '0, found: 1'b0, fpos: '0,
                 count: '0, last: 1'b1};

    case (state_r)
      ST_EXEC: begin
        round_nxt = '0;
        case (req_t'(req_r))
          REQ_INS_FRONT, REQ_INS_REAR, REQ_INS_POS: begin
            emit = out_free;
            if ((req_t'(req_r) == REQ_INS_POS) && !ins_pos_ok) begin
              res_nxt.status = STAT_BADPOS;
            end else if (full) begin
              res_nxt.status = STAT_FULL;
            end else if (out_free) begin
              cmd.op    = CELL_INS;
              count_nxt = count_r + cnt_t'(1);
              case (req_t'(req_r))
                REQ_INS_FRONT: cmd.idx = '0;
                REQ_INS_REAR:  cmd.idx = count_r;
                default:       cmd.idx = pos_idx;
              endcase
            end
          end
          REQ_DEL_FRONT, REQ_DEL_REAR, REQ_DEL_POS: begin
            emit = out_free;
            if (empty) begin
              res_nxt.status = STAT_EMPTY;
            end else if ((req_t'(req_r) == REQ_DEL_POS) && !del_pos_ok) begin
              res_nxt.status = STAT_BADPOS;
            end else begin
              res_nxt.value = del_val;
              if (out_free) begin
                cmd.op    = CELL_DEL;
                cmd.idx   = del_idx;
                count_nxt = count_r - cnt_t'(1);
              end
            end
          end
          REQ_SEARCH: begin
            emit = out_free;
            if (empty) begin
              res_nxt.status = STAT_EMPTY;
            end else if (hit_any) begin
              res_nxt.found = 1'b1;
              res_nxt.fpos  = pos_t'(hit_idx) + pos_t'(1);
            end
          end
          REQ_REVERSE: begin
            // A one-entry list needs no swap rounds.
            if (empty) begin
              emit           = out_free;
              res_nxt.status = STAT_EMPTY;
            end else if (single) begin
              emit = out_free;
            end
          end
          REQ_DISPLAY: begin
            if (empty) begin
              emit           = out_free;
              res_nxt.status = STAT_EMPTY;
            end
          end
          default: begin
            emit = out_free;
          end
        endcase
      end
      ST_SWAP: begin
        cmd.op    = CELL_SWAP;
        round_nxt = round_r + cnt_t'(1);
      end
      ST_FIN: begin
        emit = out_free;
      end
      ST_DISP: begin
        // The head entry goes out and wraps to the rear of the list, so after
        // count steps the list is back in its original order.
        if (out_free) begin
          emit          = 1'b1;
          res_nxt.value = cell_data[0];
          res_nxt.last  = last_step;
          cmd.op        = CELL_ROT;
          cmd.value     = cell_data[0];
          round_nxt     = round_r + cnt_t'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    res_nxt.count = pos_t'(count_nxt);
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      req_r <= in_req_type;
      val_r <= in_item_value;
      pos_r <= in_position;
    end
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_value          = res_r.value;
  assign out_found          = res_r.found;
  assign out_found_position = res_r.fpos;
  assign out_entry_count    = res_r.count;
  assign out_last           = res_r.last;

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Swap rounds reorder entries but never change how many there are.
  a_swap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP) |=> (count_r == $past(count_r)))
    else $error("entry count changed during reverse");

  // The final entry of a display ends the request.
  a_disp_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DISP) && emit && res_nxt.last) |=> (state_r == ST_IDLE))
    else $error("display did not finish after its last entry");

endmodule
